// ===== rtl/csv_field_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_macros
// Assertion helpers for the csv field tokenizer.
// ----------------------------------------------------------------------------
// each macro expects clk and arst_n in scope
`ifndef CSV_FIELD_TOKENIZER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSVTOK_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csv tokenizer check failed");

// next-cycle implication, checked outside reset
`define CSVTOK_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csv tokenizer check failed");

`endif

// ===== rtl/csvtok_pkg.sv =====
// ----------------------------------------------------------------------------
// csvtok_pkg
// Types and character constants shared by the csv field tokenizer modules.
// ----------------------------------------------------------------------------
package csvtok_pkg;

	// highest field index before the counter saturates
	localparam int MAX_FIELD_INDEX = 255;
	localparam int FIELD_LIMIT     = (MAX_FIELD_INDEX < 255) ? MAX_FIELD_INDEX : 255;
	localparam logic [7:0] FIELD_LIMIT_C = 8'(FIELD_LIMIT);

	// special characters
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// input item
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_marker;
	} in_item_t;

	// result item
	typedef struct packed {
		logic       has_byte;
		logic [7:0] cell_byte;
		logic       field_done;
		logic       row_done;
		logic [7:0] field_number;
	} out_item_t;

	// tokenizer state
	typedef struct packed {
		logic       quoted_mode;
		logic       quote_pending;
		logic       field_open;
		logic [7:0] field_counter;
	} tok_state_t;

	// result of one step
	typedef struct packed {
		logic      emit;
		out_item_t item;
	} step_res_t;

endpackage

// ===== rtl/csvtok_step.sv =====
// ----------------------------------------------------------------------------
// csvtok_step
// Combinational step: one input item plus the current state gives the next
// state and at most one result item.
// ----------------------------------------------------------------------------
module csvtok_step import csvtok_pkg::*; (
	input  tok_state_t state,
	input  in_item_t   item,
	output tok_state_t state_next,
	output step_res_t  res
);

	logic [7:0] b;
	logic       unquoted;

	assign b = item.text_byte;

	always_comb begin
		state_next = state;
		res = '0;
		res.item.field_number = state.field_counter;
		unquoted = 1'b0;

		// end of text, pending quote, quoted body, or plain position
		if (item.end_marker) begin
			res.emit = state.field_open;
			res.item.field_done = 1'b1;
			res.item.row_done = 1'b1;
			state_next = '0;
		end else if (state.quote_pending) begin
			state_next.quote_pending = 1'b0;
			if (b == CH_QUOTE) begin
				res.emit = 1'b1;
				res.item.has_byte = 1'b1;
				res.item.cell_byte = b;
			end else begin
				state_next.quoted_mode = 1'b0;
				unquoted = 1'b1;
			end
		end else if (state.quoted_mode) begin
			state_next.field_open = 1'b1;
			if (b == CH_QUOTE) begin
				state_next.quote_pending = 1'b1;
			end else begin
				res.emit = 1'b1;
				res.item.has_byte = 1'b1;
				res.item.cell_byte = b;
			end
		end else begin
			unquoted = 1'b1;
		end

		// byte handling in an unquoted position
		if (unquoted) begin
			case (b)
				CH_QUOTE: begin
					state_next.quoted_mode = 1'b1;
					state_next.field_open = 1'b1;
				end
				CH_COMMA: begin
					res.emit = 1'b1;
					res.item.field_done = 1'b1;
					if (state.field_counter < FIELD_LIMIT_C)
						state_next.field_counter = state.field_counter + 8'd1;
					state_next.field_open = 1'b1;
				end
				CH_LF, CH_CR: begin
					if (state.field_open) begin
						res.emit = 1'b1;
						res.item.field_done = 1'b1;
						res.item.row_done = 1'b1;
						state_next.field_open = 1'b0;
						state_next.field_counter = '0;
					end
				end
				default: begin
					state_next.field_open = 1'b1;
					res.emit = 1'b1;
					res.item.has_byte = 1'b1;
					res.item.cell_byte = b;
				end
			endcase
		end
	end

endmodule

// ===== rtl/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming csv tokenizer: unquotes and unescapes cell bytes and marks
// field and row ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_item carries one text byte or an
//   end-of-text marker per transfer. Output channel out_valid/out_ready/
//   out_item carries zero or one result per input item, in input order.
//   An input item passes through the input register and then the result
//   register on its way to out_item. The block takes one item per cycle
//   while the receiver does not stall; the state update sits in one short
//   combinational step between the two registers.
//   Items that give no result (quotes that open or close quoting, blank
//   newlines, end of text with no open field) are dropped at the step.
//   When the receiver stalls, the result register holds; the input register
//   takes at most one more item, then in_ready stays low until out_ready
//   returns.
//   Reset clears the quoting state, the field flag, the field index and
//   both valid flags; no item is in flight after reset.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_macros.svh"

module csv_field_tokenizer import csvtok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       valid_s2;
	out_item_t  item_s2;
	tok_state_t state_q;
	tok_state_t state_next;
	step_res_t  res;
	logic       advance;
	logic       fire_s1;

	// pipeline moves whenever the result register is free or being drained
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign fire_s1   = valid_s1 && advance;
	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	// tokenizer step
	csvtok_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.res        (res)
	);

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire_s1 && res.emit;
			if (fire_s1)
				state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire_s1 && res.emit)
			item_s2 <= res.item;
	end

	// checks
	`CSVTOK_ASSERT_IMP(a_row_ends_field, out_valid && out_item.row_done, out_item.field_done)
	`CSVTOK_ASSERT_IMP(a_byte_not_end, out_valid && out_item.has_byte, !out_item.field_done)
	`CSVTOK_ASSERT_IMP(a_pending_in_quotes, state_q.quote_pending, state_q.quoted_mode)
	`CSVTOK_ASSERT_NXT(a_end_clears, fire_s1 && item_s1.end_marker, state_q == '0)

endmodule

// ===== tb/csv_field_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb
// Self-checking bench for the streaming csv tokenizer. A queue of text bytes
// and end markers feeds a valid/ready driver with random idle bursts; a
// monitor predicts each result from its own copy of the quoting state and
// compares every output transfer field by field, in order.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_tb import csvtok_pkg::*;;

	typedef struct {
		in_item_t item;
		bit       drain;
	} text_ent_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	text_ent_t text_q[$];
	out_item_t cell_q[$];

	// tokenizer state as predicted by the bench
	bit         m_quoted;
	bit         m_pend_quote;
	bit         m_open;
	logic [7:0] m_index;

	bit in_took;
	int settle;
	int in_gap;
	int out_gap;
	int errors;
	int n_items;
	int n_results;
	int n_rows;
	int max_idx;

	csv_field_tokenizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_err(string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_err($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// a byte seen outside quotes (also after a quote that closes quoting)
	function automatic bit plain_step(logic [7:0] b, output out_item_t res);
		res = '0;
		res.field_number = m_index;
		if (b == CH_QUOTE) begin
			m_quoted = 1'b1;
			m_open = 1'b1;
			return 1'b0;
		end
		if (b == CH_COMMA) begin
			res.field_done = 1'b1;
			if (m_index < FIELD_LIMIT_C)
				m_index = m_index + 8'd1;
			m_open = 1'b1;
			return 1'b1;
		end
		if (b == CH_LF || b == CH_CR) begin
			if (!m_open)
				return 1'b0;
			res.field_done = 1'b1;
			res.row_done = 1'b1;
			m_open = 1'b0;
			m_index = '0;
			return 1'b1;
		end
		m_open = 1'b1;
		res.has_byte = 1'b1;
		res.cell_byte = b;
		return 1'b1;
	endfunction

	// next state and optional result for one accepted text item
	function automatic bit tokenize_step(in_item_t it, output out_item_t res);
		res = '0;
		res.field_number = m_index;
		if (it.end_marker) begin
			res.field_done = 1'b1;
			res.row_done = 1'b1;
			tokenize_step = m_open;
			m_quoted = 1'b0;
			m_pend_quote = 1'b0;
			m_open = 1'b0;
			m_index = '0;
			return tokenize_step;
		end
		if (m_pend_quote) begin
			m_pend_quote = 1'b0;
			if (it.text_byte == CH_QUOTE) begin
				res.has_byte = 1'b1;
				res.cell_byte = CH_QUOTE;
				return 1'b1;
			end
			m_quoted = 1'b0;
			return plain_step(it.text_byte, res);
		end
		if (m_quoted) begin
			m_open = 1'b1;
			if (it.text_byte == CH_QUOTE) begin
				m_pend_quote = 1'b1;
				return 1'b0;
			end
			res.has_byte = 1'b1;
			res.cell_byte = it.text_byte;
			return 1'b1;
		end
		return plain_step(it.text_byte, res);
	endfunction

	// stimulus builders
	task automatic push_byte(logic [7:0] b);
		text_ent_t e;
		e.item.text_byte = b;
		e.item.end_marker = 1'b0;
		e.drain = 1'b0;
		text_q.push_back(e);
	endtask

	task automatic push_end();
		text_ent_t e;
		e.item.text_byte = 8'($urandom);
		e.item.end_marker = 1'b1;
		e.drain = 1'b0;
		text_q.push_back(e);
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic gen_field();
		int len;
		int pick;
		if ($urandom_range(0, 9) < 6) begin
			len = $urandom_range(0, 4);
			repeat (len) push_byte(plain_byte());
		end else begin
			push_byte(CH_QUOTE);
			len = $urandom_range(0, 5);
			repeat (len) begin
				pick = $urandom_range(0, 99);
				if (pick < 20)
					push_byte(CH_COMMA);
				else if (pick < 30)
					push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
				else if (pick < 45)
					push_str("\"\"");
				else
					push_byte(plain_byte());
			end
			push_byte(CH_QUOTE);
			// stray text after the closing quote
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 3)) push_byte(plain_byte());
		end
	endtask

	task automatic gen_row();
		int nf;
		nf = $urandom_range(1, 6);
		for (int f = 0; f < nf; f++) begin
			gen_field();
			if (f < nf - 1)
				push_byte(CH_COMMA);
		end
		case ($urandom_range(0, 19))
			0: ;
			1, 2, 3, 4, 5, 6: push_byte(CH_CR);
			7, 8, 9, 10, 11, 12: push_byte(CH_LF);
			default: begin
				push_byte(CH_CR);
				push_byte(CH_LF);
			end
		endcase
	endtask

	// input driver, changes at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold until the transfer happens
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap--;
		end else if (text_q.size() == 0) begin
			in_valid <= 1'b0;
		end else if (text_q[0].drain && (cell_q.size() != 0 || settle < 4)) begin
			in_valid <= 1'b0;
		end else if (text_q.size() > 120 && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			in_gap = $urandom_range(1, 15) - 1;
		end else begin
			in_item <= text_q[0].item;
			in_valid <= 1'b1;
			void'(text_q.pop_front());
		end
	end

	// result sink stalls in bursts as well
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else if (text_q.size() > 120 && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			out_gap = $urandom_range(1, 15) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: check result transfers, then predict from input transfers
	always @(posedge clk) begin : mon
		out_item_t want;
		out_item_t got;
		bit        emit;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = out_item;
				n_results++;
				if (cell_q.size() == 0) begin
					report_err("result with nothing pending");
				end else begin
					want = cell_q.pop_front();
					check_field("has_byte", got.has_byte, want.has_byte);
					check_field("cell_byte", got.cell_byte, want.cell_byte);
					check_field("field_done", got.field_done, want.field_done);
					check_field("row_done", got.row_done, want.row_done);
					check_field("field_number", got.field_number, want.field_number);
				end
			end
			in_took = in_valid && in_ready;
			if (in_took) begin
				n_items++;
				settle = 0;
				emit = tokenize_step(in_item, want);
				if (emit) begin
					cell_q.push_back(want);
					if (want.row_done)
						n_rows++;
					if (want.field_number > max_idx)
						max_idx = want.field_number;
				end
			end else if (settle < 1000) begin
				settle++;
			end
		end
	end

	initial begin
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;

		// directed: byte extremes, escapes, closing quote before comma and row end,
		// blank lines, unclosed quote at end of text, end with no open field
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_COMMA);
		push_str("\"a\"\"b\"");
		push_byte(CH_COMMA);
		push_str("\"z\"");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_CR);
		push_str("\"\"x");
		push_byte(CH_LF);
		push_str("\"q");
		push_end();
		push_end();

		// one long row to run the field index into saturation
		text_q[text_q.size() - 1].drain = 1'b1;
		push_byte(8'h6B);
		for (int i = 0; i < 262; i++) begin
			push_byte(CH_COMMA);
			if ($urandom_range(0, 15) == 0)
				push_byte(plain_byte());
		end
		push_byte(CH_CR);

		// random records, with some noise, blank lines and end markers
		while (text_q.size() < 950) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
			end else if (pick < 12) begin
				push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
			end else if (pick < 15) begin
				push_end();
			end else begin
				gen_row();
			end
		end
		text_q[600].drain = 1'b1;
		push_end();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (text_q.size() == 0 && !in_valid);
		wait (cell_q.size() == 0);
		repeat (10) @(posedge clk);

		$display("covered %0d text items, %0d results, %0d rows ended, top field index %0d",
			n_items, n_results, n_rows, max_idx);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("timeout: %0d results still pending", cell_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/csvtok_pkg.sv
rtl/csvtok_step.sv
rtl/csv_field_tokenizer.sv
tb/csv_field_tokenizer_tb.sv
